[design/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_unit; depends on nothing else.
package spq_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int ITEM_W         = 32;
  localparam int POS_W          = 4;
  localparam int CNT_W          = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [ITEM_W-1:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ITEM_W-1:0] result_value;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic compare;
    logic apply;
    logic rd_start;
    logic read_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       out_free;
    logic       read_last;
  } dp_stat_t;

endpackage

[design/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// This block keeps up to CAPACITY signed values of DATA_WIDTH bits in a row
// of cells sorted in descending order, position 0 holding the largest. Each
// request carries an action and a value. An insert places the value ahead of
// the first stored value that is less than or equal to it, so a new value
// goes ahead of equal values already stored, or answers full when the row is
// occupied. A delete removes the first stored value equal to the given one
// and closes the gap, or answers empty or not found. A read-out returns every
// stored value in order, one result per cycle while the result side does not
// stall, with last set on the final one; on an empty queue it returns a
// single empty result. Action code 3 is accepted and ignored. Every cell
// compares against the request value in parallel, the compare vectors are
// registered, and the insert or delete shift follows once the output register
// has room. A new request can be taken in the same cycle that an insert,
// delete or empty read-out is applied. A read-out holds off the next request
// until its last entry has left through cell 0, while the occupied cells
// rotate by one at each step. Results sit in an output register, so a stalled
// result does not lose the next request's comparison work. After reset the
// queue is empty and ready at once; no clearing pass is needed.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  // Commands flow from the controller to the datapath, and status flows back.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller sequences each request: accept, compare, then apply or
  // start a read-out run that it steps one result at a time.
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the cells, the entry count and the output register.
  spq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

[design/spq_ctrl.sv]
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the command and status structs and the action codes.
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   apply_done;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    apply_done = 1'b0;
    case (state_r)
      S_IDLE: begin
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        if (stat.out_free) begin
          if (stat.action == ACT_READ && !stat.empty) begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_READ;
          end else begin
            cmd.apply  = 1'b1;
            apply_done = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.read_step = 1'b1;
          if (stat.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A new request may enter in the same cycle that an insert, delete or empty read is applied.
    in_stall      = !(state_r == S_IDLE || apply_done);
    cmd.load_item = in_valid && !in_stall;
    if (cmd.load_item) begin
      state_nxt = S_CMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> in_stall)
    else $error("request accepted during read-out");

  a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply || cmd.read_step) |-> stat.out_free)
    else $error("result issued while output register is occupied");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.compare, cmd.apply, cmd.rd_start, cmd.read_step}))
    else $error("conflicting datapath commands");

endmodule

[design/spq_dp.sv]
// Datapath of the sorted priority queue: the sorted cell row, count, compare
// vectors and the output register. Depends on spq_pkg.
module spq_dp import spq_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  input  in_req_t   in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output out_req_t  out_req
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  logic signed [DATA_WIDTH-1:0] cell_r   [CAPACITY];
  logic signed [DATA_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [COUNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [1:0]                   action_r;
  logic signed [DATA_WIDTH-1:0] key_r, key_in;
  logic [ITEM_W-1:0]            key_out, head_out;
  logic [CAPACITY-1:0]          ge_c, eq_c, first_c, ge_r, first_r;
  logic                         found_r;
  logic [IDX_W-1:0]             pos_enc;
  logic                         full, empty, read_last;
  out_req_t                     res, out_r;
  logic                         res_load, out_valid_r;

  // Narrow data is sign-extended to the 32-bit fields; wide data takes the
  // 32-bit value as a non-negative number.
  if (DATA_WIDTH <= ITEM_W) begin : g_key_narrow
    assign key_in = in_req.item_value[DATA_WIDTH-1:0];
  end else begin : g_key_wide
    assign key_in = {{(DATA_WIDTH-ITEM_W){1'b0}}, in_req.item_value};
  end

  if (DATA_WIDTH < ITEM_W) begin : g_out_narrow
    assign key_out  = {{(ITEM_W-DATA_WIDTH){key_r[DATA_WIDTH-1]}}, key_r};
    assign head_out = {{(ITEM_W-DATA_WIDTH){cell_r[0][DATA_WIDTH-1]}}, cell_r[0]};
  end else begin : g_out_wide
    assign key_out  = key_r[ITEM_W-1:0];
    assign head_out = cell_r[0][ITEM_W-1:0];
  end

  assign full      = (count_r == COUNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign read_last = ((COUNT_W'(rd_idx_r) + COUNT_W'(1)) == count_r);

  // Every cell compares against the key at once. Unused cells count as
  // "key >= cell", so the ge vector is a thermometer and its first set bit
  // is the insert slot, or the first candidate for a delete.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_c[i] = (COUNT_W'(i) >= count_r) || (key_r >= cell_r[i]);
      eq_c[i] = (COUNT_W'(i) < count_r) && (key_r == cell_r[i]);
    end
    first_c[0] = ge_c[0];
    for (int i = 1; i < CAPACITY; i++) begin
      first_c[i] = ge_c[i] && !ge_c[i-1];
    end
  end

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_r[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cell_nxt   = cell_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    res        = '0;
    res_load   = 1'b0;
    if (cmd.apply) begin
      case (action_r)
        ACT_INSERT: begin
          res_load         = 1'b1;
          res.result_value = key_out;
          res.last         = 1'b1;
          if (full) begin
            res.status      = ST_FULL;
            res.entry_count = CNT_W'(count_r);
          end else begin
            count_nxt       = count_r + COUNT_W'(1);
            res.status      = ST_OK;
            res.position    = POS_W'(pos_enc);
            res.entry_count = CNT_W'(count_nxt);
            if (first_r[0]) begin
              cell_nxt[0] = key_r;
            end
            for (int i = 1; i < CAPACITY; i++) begin
              if (first_r[i]) begin
                cell_nxt[i] = key_r;
              end else if (ge_r[i]) begin
                cell_nxt[i] = cell_r[i-1];
              end
            end
          end
        end
        ACT_DELETE: begin
          res_load         = 1'b1;
          res.result_value = key_out;
          res.last         = 1'b1;
          if (empty) begin
            res.status = ST_EMPTY;
          end else if (!found_r) begin
            res.status      = ST_NOT_FOUND;
            res.entry_count = CNT_W'(count_r);
          end else begin
            count_nxt       = count_r - COUNT_W'(1);
            res.status      = ST_OK;
            res.position    = POS_W'(pos_enc);
            res.entry_count = CNT_W'(count_nxt);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (ge_r[i]) begin
                cell_nxt[i] = cell_r[i+1];
              end
            end
          end
        end
        ACT_READ: begin
          // Only an empty queue reaches here; a full read-out runs by steps.
          res_load   = 1'b1;
          res.status = ST_EMPTY;
          res.last   = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end
    if (cmd.read_step) begin
      res_load         = 1'b1;
      res.status       = ST_OK;
      res.result_value = head_out;
      res.position     = POS_W'(rd_idx_r);
      res.entry_count  = CNT_W'(count_r);
      res.last         = read_last;
      rd_idx_nxt       = rd_idx_r + IDX_W'(1);
      // Rotate the occupied cells by one; after count steps they are back in order.
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (COUNT_W'(i) == count_r - COUNT_W'(1)) begin
          cell_nxt[i] = cell_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      action_r    <= ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_item) begin
        action_r <= in_req.action;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r   <= cell_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (cmd.load_item) begin
      key_r <= key_in;
    end
    if (cmd.compare) begin
      ge_r    <= ge_c;
      first_r <= first_c;
      found_r <= |(first_c & eq_c);
    end
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  assign stat.action    = action_r;
  assign stat.empty     = empty;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.read_last = read_last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_step |=> $stable(count_r))
    else $error("read-out changed the entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && action_r == ACT_INSERT && !full) |=>
      (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("insert did not add one entry");

endmodule

[bench/spq_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the sorted priority queue bench: a shadow of the sorted cells
// and the list of results still owed by the block. Depends on spq_pkg.
package spq_tb_pkg;
  import spq_pkg::*;

  class sorted_queue_scoreboard;
    localparam int unsigned MAX_PRINTED = 40;

    // Shadow of the cell row, largest value first, and its fill level.
    logic signed [ITEM_W-1:0] cells [DEF_CAPACITY];
    int unsigned stored;
    out_req_t owed_results[$];
    int unsigned mismatch_count;
    int unsigned results_seen;

    function new();
      stored = 0;
      mismatch_count = 0;
      results_seen = 0;
    endfunction

    function void owe(status_t st, logic signed [ITEM_W-1:0] val, int unsigned pos,
                      int unsigned cnt, bit last_flag);
      out_req_t r;
      r.status       = st;
      r.result_value = val;
      r.position     = POS_W'(pos);
      r.entry_count  = CNT_W'(cnt);
      r.last         = last_flag;
      owed_results.push_back(r);
    endfunction

    function int unsigned pending_count();
      return owed_results.size();
    endfunction

    // Applies one accepted request to the shadow row and queues its results.
    function void note_request(in_req_t req);
      logic signed [ITEM_W-1:0] v;
      int unsigned slot;
      int unsigned j;
      v = req.item_value;
      case (action_t'(req.action))
        ACT_INSERT: begin
          if (stored >= DEF_CAPACITY) begin
            owe(ST_FULL, v, 0, stored, 1'b1);
          end else begin
            // A new value goes ahead of any equal values already stored.
            slot = 0;
            while (slot < stored && v < cells[slot]) slot++;
            for (j = stored; j > slot; j--) cells[j] = cells[j-1];
            cells[slot] = v;
            stored++;
            owe(ST_OK, v, slot, stored, 1'b1);
          end
        end
        ACT_DELETE: begin
          if (stored == 0) begin
            owe(ST_EMPTY, v, 0, 0, 1'b1);
          end else begin
            slot = 0;
            while (slot < stored && cells[slot] != v) slot++;
            if (slot == stored) begin
              owe(ST_NOT_FOUND, v, 0, stored, 1'b1);
            end else begin
              for (j = slot; j + 1 < stored; j++) cells[j] = cells[j+1];
              stored--;
              owe(ST_OK, v, slot, stored, 1'b1);
            end
          end
        end
        ACT_READ: begin
          if (stored == 0) begin
            owe(ST_EMPTY, '0, 0, 0, 1'b1);
          end else begin
            for (j = 0; j < stored; j++) owe(ST_OK, cells[j], j, stored, j + 1 == stored);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t: %s", $time, what);
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      string diffs;
      results_seen++;
      if (owed_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed: status %0d value %0d pos %0d",
                         results_seen, got.status, got.result_value, got.position));
      end else begin
        want = owed_results.pop_front();
        diffs = "";
        if (got.status !== want.status)
          diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
        if (got.result_value !== want.result_value)
          diffs = {diffs, $sformatf(" value %0d/%0d", got.result_value, want.result_value)};
        if (got.position !== want.position)
          diffs = {diffs, $sformatf(" position %0d/%0d", got.position, want.position)};
        if (got.entry_count !== want.entry_count)
          diffs = {diffs, $sformatf(" count %0d/%0d", got.entry_count, want.entry_count)};
        if (got.last !== want.last)
          diffs = {diffs, $sformatf(" last %0b/%0b", got.last, want.last)};
        if (diffs != "") report($sformatf("result %0d got/owed:%s", results_seen, diffs));
      end
    endtask
  endclass

endpackage

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the sorted priority queue bench: clock, reset, request driver and
// result sink around sorted_priority_queue_unit. Depends on spq_pkg and spq_tb_pkg.
module testbench;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  // The random part stops after this many requests that the block acts on.
  localparam int unsigned RANDOM_REQUESTS = 300;
  // This covers the longest read-out with room to spare.
  localparam int unsigned DRAIN_CYCLES    = 40;
  // Length of the one long hold-off on the result side.
  localparam int unsigned PRESSURE_CYCLES = 120;
  // Worst case is far below this: every request a read-out of 16 results, with long stalls.
  localparam int unsigned TIMEOUT_NS      = 2_000_000;

  // Phases of the random part steer the fill level of the queue.
  typedef enum int {PH_LOAD, PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  sorted_queue_scoreboard sb;

  sorted_priority_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Many values come from a narrow band so that duplicates and delete hits
  // are common, with the extremes and full-width random words mixed in.
  function automatic logic signed [ITEM_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return ITEM_W'($urandom_range(0, 15)) - ITEM_W'(8);
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Most deletes name a value that is stored right now, so they really remove
  // something; the rest usually miss.
  function automatic logic signed [ITEM_W-1:0] delete_value();
    if (sb.stored > 0 && $urandom_range(0, 3) != 0)
      return sb.cells[$urandom_range(0, sb.stored - 1)];
    return random_value();
  endfunction

  function automatic action_t pick_action(phase_kind_t phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_LOAD:  return ACT_INSERT;
      PH_FILL:  return r < 78 ? ACT_INSERT : r < 88 ? ACT_DELETE : r < 98 ? ACT_READ : ACT_NONE;
      PH_DRAIN: return r < 20 ? ACT_INSERT : r < 80 ? ACT_DELETE : r < 97 ? ACT_READ : ACT_NONE;
      default:  return r < 40 ? ACT_INSERT : r < 72 ? ACT_DELETE : r < 96 ? ACT_READ : ACT_NONE;
    endcase
  endfunction

  // Gaps between requests: mostly none or short, now and then a long one.
  // A steady phase sends back to back.
  function automatic int unsigned sender_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Offers one request from the next falling edge and holds it until it is
  // taken at a rising edge; the shadow model is updated at that same edge.
  task automatic send_request(input action_t act, input logic signed [ITEM_W-1:0] val);
    in_req_t req;
    req.action     = act;
    req.item_value = val;
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  // Drops valid for the given number of cycles. With no gap, valid simply
  // stays high into the next request.
  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned phase_left;
    phase_kind_t phase;
    bit steady;
    action_t act;
    logic signed [ITEM_W-1:0] val;

    sb = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty cases first, then the extremes of the value range,
    // a duplicate, a miss, and deletes at the head, middle and tail.
    send_request(ACT_READ, random_value());
    send_request(ACT_DELETE, 32'sd5);
    send_request(ACT_NONE, $urandom);
    send_request(ACT_INSERT, 32'h7fff_ffff);
    idle_sender(sender_gap(1'b0));
    send_request(ACT_INSERT, 32'h8000_0000);
    send_request(ACT_INSERT, 32'sd0);
    send_request(ACT_INSERT, 32'sd0);
    idle_sender(sender_gap(1'b0));
    send_request(ACT_INSERT, -32'sd1);
    send_request(ACT_INSERT, 32'sd1);
    send_request(ACT_NONE, 32'sd1);
    send_request(ACT_DELETE, 32'sd12345);
    send_request(ACT_READ, 32'hffff_ffff);
    send_request(ACT_DELETE, 32'sd0);
    idle_sender(sender_gap(1'b0));
    send_request(ACT_DELETE, 32'h8000_0000);
    send_request(ACT_DELETE, 32'h7fff_ffff);
    send_request(ACT_READ, 32'sd0);

    // Random part. It opens with inserts only, which runs the queue into the
    // full case; after that the phases alternate between filling, draining
    // and an even mix so the fill level wanders over its whole range.
    counted    = 0;
    phase      = PH_LOAD;
    phase_left = 20;
    steady     = 1'b0;
    while (counted < RANDOM_REQUESTS) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       phase = PH_FILL;
          1:       phase = PH_DRAIN;
          default: phase = PH_MIXED;
        endcase
        phase_left = $urandom_range(15, 40);
        steady     = ($urandom_range(0, 3) == 0);
      end
      act = pick_action(phase);
      val = (act == ACT_DELETE) ? delete_value() : random_value();
      send_request(act, val);
      // Ignored requests do not count toward the total.
      if (act != ACT_NONE) begin
        counted++;
        phase_left--;
      end
      idle_sender(sender_gap(steady));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    // Anything the block sends after this point is caught as unowed.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side back-pressure. It alternates between quiet stretches with no
  // stall at all and busy stretches with short and occasional long stalls.
  // Once, after a few dozen results, it holds off for a long time while the
  // driver keeps offering requests, so the block has to stall its input.
  initial begin : result_sink
    int unsigned hold;
    int unsigned stretch_left;
    int unsigned r;
    bit quiet;
    bit pressure_done;
    out_stall     = 1'b0;
    hold          = 0;
    stretch_left  = 0;
    quiet         = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(50, 150);
        quiet        = ($urandom_range(0, 3) == 0);
      end
      stretch_left--;
      if (hold == 0 && !pressure_done && sb != null && sb.results_seen >= 40) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_CYCLES;
      end
      if (hold == 0 && !quiet) begin
        r = $urandom_range(0, 99);
        if (r >= 92) hold = $urandom_range(10, 40);
        else if (r >= 65) hold = $urandom_range(1, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Results are taken at the rising edge where valid is up and stall is down.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_req);
  end

endmodule
